// ===== src/mdg_pkg.sv =====
`timescale 1ns / 1ps

package mdg_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;

    // Internal orbit arithmetic is 64-bit signed with saturating adds.
    localparam int ZW = 64;
    typedef logic signed [ZW-1:0] t_z;

    localparam int ITER_W = 16;
    localparam int RAD_W  = 31;
    localparam int SLP_W  = 31;
    localparam int STP_W  = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [ITER_W-1:0] ITER_LIM_RST = 16'd256;
    localparam logic [RAD_W-1:0]  RADIUS_RST   = 31'd1073741824;
    localparam logic [SLP_W-1:0]  SLOPE_RST    = 31'd268435456;
    localparam logic [STP_W-1:0]  STEP_RST     = 29'd26843546;

    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd3;

    localparam logic [1:0] RUN_CENTER = 2'd0;
    localparam logic [1:0] RUN_RIGHT  = 2'd1;
    localparam logic [1:0] RUN_UP     = 2'd2;

    localparam logic [15:0] SHADE_ONE = 16'd32768;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_R2,
        MUL_S2,
        MUL_SR,
        MUL_SI,
        MUL_X,
        MUL_VX,
        MUL_VY,
        MUL_T2
    } t_mul;

    typedef struct packed {
        logic       load;
        t_mul       mul;
        logic [1:0] run;
        logic       run_init;
        logic       upd;
        logic       chk_ld;
        logic       tst_ld;
        logic       dw_wr;
        logic       dw_max;
        logic       d_ld;
        logic       q_start;
        logic       q_step;
        logic       q_take;
        logic       q_next;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic zero_iter;
        logic esc_mag;
        logic esc_sq;
        logic last_iter;
        logic t_ok;
        logic mq_zero;
        logic fits;
        logic mask_last;
    } t_sts;

    function automatic t_z sat_add(input t_z a, input t_z b);
        t_z s;
        s = a + b;
        if (a[ZW-1] == b[ZW-1] && s[ZW-1] != a[ZW-1]) begin
            s = b[ZW-1] ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

// ===== src/mdg_ctrl.sv =====
`timescale 1ns / 1ps

module mdg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  mdg_pkg::t_sts   i_sts,
    output mdg_pkg::t_cmd   o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_R2   = 17'h00002,
        S_INIT = 17'h00004,
        S_UPD  = 17'h00008,
        S_CHK  = 17'h00010,
        S_MSR  = 17'h00020,
        S_MSI  = 17'h00040,
        S_MX   = 17'h00080,
        S_TST  = 17'h00100,
        S_VX   = 17'h00200,
        S_VY   = 17'h00400,
        S_S2   = 17'h00800,
        S_D    = 17'h01000,
        S_QT   = 17'h02000,
        S_QM   = 17'h04000,
        S_QC   = 17'h08000,
        S_DONE = 17'h10000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_run, n_run;
    logic       r_ov, n_ov;
    t_state     w_after_run;
    logic [1:0] w_run_inc;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;

    always_comb begin
        if (r_run == mdg_pkg::RUN_UP) begin
            w_after_run = S_VX;
            w_run_inc   = r_run;
        end else begin
            w_after_run = S_INIT;
            w_run_inc   = r_run + 2'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_run   = r_run;
        n_ov    = r_ov && !i_m_tready;
        o_cmd   = '0;
        o_cmd.run = r_run;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_R2;
                end
            end
            S_R2: begin
                o_cmd.mul = mdg_pkg::MUL_R2;
                n_run     = mdg_pkg::RUN_CENTER;
                n_state   = S_INIT;
            end
            S_INIT: begin
                o_cmd.run_init = 1'b1;
                if (i_sts.zero_iter) begin
                    // With a zero limit, writing the limit itself gives the dwell of zero.
                    o_cmd.dw_wr  = 1'b1;
                    o_cmd.dw_max = 1'b1;
                    n_run        = w_run_inc;
                    n_state      = w_after_run;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (i_sts.esc_mag) begin
                    o_cmd.dw_wr = 1'b1;
                    n_run       = w_run_inc;
                    n_state     = w_after_run;
                end else begin
                    o_cmd.chk_ld = 1'b1;
                    n_state      = S_MSR;
                end
            end
            S_MSR: begin
                o_cmd.mul = mdg_pkg::MUL_SR;
                n_state   = S_MSI;
            end
            S_MSI: begin
                o_cmd.mul = mdg_pkg::MUL_SI;
                n_state   = S_MX;
            end
            S_MX: begin
                o_cmd.mul = mdg_pkg::MUL_X;
                n_state   = S_TST;
            end
            S_TST: begin
                if (i_sts.esc_sq || i_sts.last_iter) begin
                    o_cmd.dw_wr  = 1'b1;
                    o_cmd.dw_max = !i_sts.esc_sq;
                    n_run        = w_run_inc;
                    n_state      = w_after_run;
                end else begin
                    o_cmd.tst_ld = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_VX: begin
                o_cmd.mul = mdg_pkg::MUL_VX;
                n_state   = S_VY;
            end
            S_VY: begin
                o_cmd.mul = mdg_pkg::MUL_VY;
                n_state   = S_S2;
            end
            S_S2: begin
                o_cmd.mul = mdg_pkg::MUL_S2;
                n_state   = S_D;
            end
            S_D: begin
                o_cmd.d_ld = 1'b1;
                n_state    = S_QT;
            end
            S_QT: begin
                if (i_sts.t_ok) begin
                    o_cmd.mul     = mdg_pkg::MUL_T2;
                    o_cmd.q_start = 1'b1;
                    n_state       = S_QM;
                end else begin
                    o_cmd.q_next = 1'b1;
                    n_state      = i_sts.mask_last ? S_DONE : S_QT;
                end
            end
            S_QM: begin
                if (i_sts.mq_zero) begin
                    n_state = S_QC;
                end else begin
                    o_cmd.q_step = 1'b1;
                end
            end
            S_QC: begin
                o_cmd.q_take = i_sts.fits;
                o_cmd.q_next = 1'b1;
                n_state      = i_sts.mask_last ? S_DONE : S_QT;
            end
            S_DONE: begin
                if (!r_ov || i_m_tready) begin
                    o_cmd.out_ld = 1'b1;
                    n_ov         = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= mdg_pkg::RUN_CENTER;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_ov    <= n_ov;
        end
    end

endmodule

// ===== src/mdg_dp.sv =====
`timescale 1ns / 1ps

module mdg_dp #(
    parameter int COORD_WIDTH = mdg_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mdg_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mdg_pkg::t_cmd                    i_cmd,
    output mdg_pkg::t_sts                    o_sts,
    input  logic signed [COORD_WIDTH-1:0]    i_c_real,
    input  logic signed [COORD_WIDTH-1:0]    i_c_imag,
    input  logic                             i_cfg_valid,
    input  logic [mdg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mdg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [15:0]                      o_dwell_center,
    output logic [15:0]                      o_dwell_right,
    output logic [15:0]                      o_dwell_up,
    output logic [15:0]                      o_shade
);

    // Squared dwell differences fit 33 bits; D = W * 2^(2F) + s^2.
    localparam int WW = 33;
    localparam int DW = ((WW + 2 * FRAC_BITS) > 62 ? (WW + 2 * FRAC_BITS) : 62) + 1;
    localparam int PW = DW + 31;

    logic [mdg_pkg::ITER_W-1:0] r_iter_lim;
    logic [mdg_pkg::RAD_W-1:0]  r_rad;
    logic [mdg_pkg::SLP_W-1:0]  r_slope;
    logic [mdg_pkg::STP_W-1:0]  r_step;

    mdg_pkg::t_z r_cr, r_ci, r_pr, r_pi, r_zr, r_zi, r_fr, r_fi;
    logic [63:0] r_r2, r_sr, r_si, r_x, r_s2;
    logic [30:0] r_ar, r_ai;
    logic        r_xneg;
    logic [15:0] r_n;
    logic [15:0] r_dw [3];
    logic [31:0] r_vx2, r_vy2;
    logic [DW-1:0] r_d;
    logic [PW-1:0] r_acc, r_md;
    logic [30:0] r_mq;
    logic [15:0] r_q, r_mask;
    logic [15:0] r_o_c, r_o_r, r_o_u, r_o_s;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_ar, w_ai;
    mdg_pkg::t_z w_sq, w_cx, w_stepz;
    logic [15:0] w_t;
    logic signed [16:0] w_vx, w_vy;
    logic [15:0] w_vxm, w_vym;
    logic [WW-1:0] w_w;

    assign w_stepz = mdg_pkg::t_z'(r_step);
    assign w_t     = r_q | r_mask;
    assign w_vx    = $signed({1'b0, r_dw[0]}) - $signed({1'b0, r_dw[1]});
    assign w_vy    = $signed({1'b0, r_dw[0]}) - $signed({1'b0, r_dw[2]});
    assign w_vxm   = w_vx[16] ? 16'(-w_vx) : w_vx[15:0];
    assign w_vym   = w_vy[16] ? 16'(-w_vy) : w_vy[15:0];
    assign w_w     = WW'(r_vx2) + WW'(r_vy2);
    assign w_ar    = r_zr[63] ? 64'(-r_zr) : 64'(r_zr);
    assign w_ai    = r_zi[63] ? 64'(-r_zi) : 64'(r_zi);
    assign w_sq    = $signed(r_sr) - $signed(r_si);
    assign w_cx    = r_xneg ? -$signed({r_x[62:0], 1'b0}) : $signed({r_x[62:0], 1'b0});

    // One shared multiplier; each product lands in its own register.
    always_comb begin
        case (i_cmd.mul)
            mdg_pkg::MUL_R2: begin
                w_ma = 32'(r_rad);
                w_mb = 32'(r_rad);
            end
            mdg_pkg::MUL_S2: begin
                w_ma = 32'(r_slope);
                w_mb = 32'(r_slope);
            end
            mdg_pkg::MUL_SR: begin
                w_ma = 32'(r_ar);
                w_mb = 32'(r_ar);
            end
            mdg_pkg::MUL_SI: begin
                w_ma = 32'(r_ai);
                w_mb = 32'(r_ai);
            end
            mdg_pkg::MUL_X: begin
                w_ma = 32'(r_ar);
                w_mb = 32'(r_ai);
            end
            mdg_pkg::MUL_VX: begin
                w_ma = 32'(w_vxm);
                w_mb = 32'(w_vxm);
            end
            mdg_pkg::MUL_VY: begin
                w_ma = 32'(w_vym);
                w_mb = 32'(w_vym);
            end
            mdg_pkg::MUL_T2: begin
                w_ma = 32'(w_t);
                w_mb = 32'(w_t);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign o_sts.zero_iter = (r_iter_lim == '0);
    assign o_sts.esc_mag   = (w_ar > 64'(r_rad)) || (w_ai > 64'(r_rad));
    assign o_sts.esc_sq    = (r_sr + r_si) > r_r2;
    assign o_sts.last_iter = ({1'b0, r_n} + 17'd1) == {1'b0, r_iter_lim};
    assign o_sts.t_ok      = (w_t <= mdg_pkg::SHADE_ONE);
    assign o_sts.mq_zero   = (r_mq == '0);
    assign o_sts.fits      = r_acc <= (PW'(r_s2) << 30);
    assign o_sts.mask_last = r_mask[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_lim <= mdg_pkg::ITER_LIM_RST;
            r_rad      <= mdg_pkg::RADIUS_RST;
            r_slope    <= mdg_pkg::SLOPE_RST;
            r_step     <= mdg_pkg::STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mdg_pkg::CFG_ITER_LIM: r_iter_lim <= i_cfg_data[mdg_pkg::ITER_W-1:0];
                mdg_pkg::CFG_RADIUS:   r_rad      <= i_cfg_data[mdg_pkg::RAD_W-1:0];
                mdg_pkg::CFG_SLOPE:    r_slope    <= i_cfg_data[mdg_pkg::SLP_W-1:0];
                mdg_pkg::CFG_STEP:     r_step     <= i_cfg_data[mdg_pkg::STP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr <= mdg_pkg::t_z'(i_c_real);
            r_ci <= mdg_pkg::t_z'(i_c_imag);
        end
        case (i_cmd.mul)
            mdg_pkg::MUL_R2: r_r2  <= w_prod;
            mdg_pkg::MUL_S2: r_s2  <= w_prod;
            mdg_pkg::MUL_SR: r_sr  <= w_prod;
            mdg_pkg::MUL_SI: r_si  <= w_prod;
            mdg_pkg::MUL_X:  r_x   <= w_prod;
            mdg_pkg::MUL_VX: r_vx2 <= w_prod[31:0];
            mdg_pkg::MUL_VY: r_vy2 <= w_prod[31:0];
            default: begin
            end
        endcase
        if (i_cmd.run_init) begin
            r_n  <= '0;
            r_fr <= '0;
            r_fi <= '0;
            case (i_cmd.run)
                mdg_pkg::RUN_RIGHT: begin
                    r_pr <= mdg_pkg::sat_add(r_cr, w_stepz);
                    r_pi <= r_ci;
                end
                mdg_pkg::RUN_UP: begin
                    r_pr <= r_cr;
                    r_pi <= mdg_pkg::sat_add(r_ci, w_stepz);
                end
                default: begin
                    r_pr <= r_cr;
                    r_pi <= r_ci;
                end
            endcase
        end
        if (i_cmd.upd) begin
            r_zr <= mdg_pkg::sat_add(r_fr, r_pr);
            r_zi <= mdg_pkg::sat_add(r_fi, r_pi);
        end
        if (i_cmd.chk_ld) begin
            // Both magnitudes are within the radius here, so 31 bits hold them.
            r_ar   <= w_ar[30:0];
            r_ai   <= w_ai[30:0];
            r_xneg <= r_zr[63] ^ r_zi[63];
        end
        if (i_cmd.tst_ld) begin
            r_fr <= w_sq >>> FRAC_BITS;
            r_fi <= w_cx >>> FRAC_BITS;
            r_n  <= r_n + 16'd1;
        end
        if (i_cmd.dw_wr) begin
            r_dw[i_cmd.run] <= i_cmd.dw_max ? r_iter_lim : r_n;
        end
        if (i_cmd.d_ld) begin
            r_d    <= (DW'(w_w) << (2 * FRAC_BITS)) + DW'(r_s2);
            r_q    <= '0;
            r_mask <= 16'h8000;
        end
        // Shift-and-add multiply t^2 * D, stopping once the multiplier runs out.
        if (i_cmd.q_start) begin
            r_acc <= '0;
            r_md  <= PW'(r_d);
            r_mq  <= w_prod[30:0];
        end
        if (i_cmd.q_step) begin
            if (r_mq[0]) begin
                r_acc <= r_acc + r_md;
            end
            r_md <= r_md << 1;
            r_mq <= r_mq >> 1;
        end
        if (i_cmd.q_take) begin
            r_q <= w_t;
        end
        if (i_cmd.q_next) begin
            r_mask <= r_mask >> 1;
        end
        if (i_cmd.out_ld) begin
            r_o_c <= r_dw[0];
            r_o_r <= r_dw[1];
            r_o_u <= r_dw[2];
            r_o_s <= r_q;
        end
    end

    assign o_dwell_center = r_o_c;
    assign o_dwell_right  = r_o_r;
    assign o_dwell_up     = r_o_u;
    assign o_shade        = r_o_s;

endmodule

// ===== src/mandelbrot_dwell_gradient.sv =====
`timescale 1ns / 1ps

// Computes Mandelbrot escape dwells at c, c+d and c+i*d for each input item and a
// shade s / |(vx, vy, s)| in Q1.15, one result item per input item. One item is
// worked on at a time, all on a single shared 32x32 multiplier: a setup product,
// then per orbit run an init state and, per iteration up to the iteration limit,
// an update, an escape check, three products and a test; then the shade
// denominator is formed and a 16-step search finds the shade, each step in
// range using a shift-and-add multiply that stops once its multiplier runs out.
// A new item is taken as soon as the previous result is in the output register.

module mandelbrot_dwell_gradient #(
    parameter int COORD_WIDTH = mdg_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mdg_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // c_real, c_imag
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // dwell_center, dwell_right, dwell_up, shade
    output logic [63:0]                         o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mdg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mdg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    mdg_pkg::t_cmd w_cmd;
    mdg_pkg::t_sts w_sts;
    logic [15:0]   w_dc, w_dr, w_du, w_sh;

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {w_sh, w_du, w_dr, w_dc};

    mdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mdg_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_c_real       (i_s_tdata[COORD_WIDTH-1:0]),
        .i_c_imag       (i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_dwell_center (w_dc),
        .o_dwell_right  (w_dr),
        .o_dwell_up     (w_du),
        .o_shade        (w_sh)
    );

endmodule
